// File: rtl/core/clit_pkg.sv
// shared types and constants of the clamped linear interpolation table core
`default_nettype none

package clit_pkg;

    localparam int KEY_W     = 24;
    localparam int FOCAL_W   = 24;
    localparam int ROWS_W    = 7;
    localparam int ROW_IDX_W = 6;
    localparam int ROW_W     = KEY_W + FOCAL_W;
    localparam int PROD_W    = KEY_W + FOCAL_W;

    // long division, one quotient bit a step
    localparam int                DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd23;

    typedef logic [1:0] t_rd_sel;
    localparam t_rd_sel RD_ZERO = 2'd0;
    localparam t_rd_sel RD_LAST = 2'd1;
    localparam t_rd_sel RD_ONE  = 2'd2;
    localparam t_rd_sel RD_NEXT = 2'd3;

    typedef logic [1:0] t_out_sel;
    localparam t_out_sel OUT_FIXED  = 2'd0;
    localparam t_out_sel OUT_ROW    = 2'd1;
    localparam t_out_sel OUT_LO     = 2'd2;
    localparam t_out_sel OUT_INTERP = 2'd3;

    typedef struct packed {
        logic     wr;
        logic     capture;
        t_rd_sel  rd_sel;
        logic     save_lo;
        logic     setup;
        logic     mul;
        logic     div_step;
        logic     out_en;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic zoom_le_row;
        logic zoom_ge_row;
        logic row_le_lo;
        logic div_last;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/core/clamped_linear_interp_table_core.sv
// top level of the clamped linear interpolation table core
//
// channel   direction  handshake                      payload
// request   in         start high while busy low      i_req_type, i_row_index,
//                                                     i_zoom_value, i_row_focal_q
// result    out        o_focal_valid, one cycle       o_focal_q
// config    in         i_cfg_valid and o_cfg_ready    i_cfg_index, i_cfg_wdata
//
// a row write is taken while idle and busy never rises for it
// a query with no rows in use or clamped at the first row ends after the first-row check,
// one clamped at the last row after the last-row check; an interpolated query runs the
// one-row-a-cycle scan for the upper bracket, which reads 1 .. rows - 1 rows, and then
// the multiply and the bit-serial divider
// the result strobe rises in the same cycle that busy falls
// synchronous active-low reset clears rows_in_use to 0 and fixed focal to 50.0 mm;
// table contents are undefined until written
// the receiver cannot stall results; config is always ready
`default_nettype none

module clamped_linear_interp_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // request channel
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_req_type,
    input  wire logic [clit_pkg::ROW_IDX_W-1:0]   i_row_index,
    input  wire logic [clit_pkg::KEY_W-1:0]       i_zoom_value,
    input  wire logic [clit_pkg::FOCAL_W-1:0]     i_row_focal_q,
    // result channel
    output logic      [clit_pkg::FOCAL_W-1:0]     o_focal_q,
    output logic                                  o_focal_valid,
    // config write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [1:0]                       i_cfg_index,
    input  wire logic [clit_pkg::FOCAL_W-1:0]     i_cfg_wdata
);

    import clit_pkg::*;

    // register indexes on the config channel
    localparam logic [1:0] CFG_ROWS_IN_USE = 2'd0;
    localparam logic [1:0] CFG_FIXED_FOCAL = 2'd1;

    // 50.0 mm in Q12.12
    localparam logic [FOCAL_W-1:0] FIXED_FOCAL_RESET = 24'd204800;

    logic [ROWS_W-1:0]  r_rows_in_use;
    logic [FOCAL_W-1:0] r_fixed_focal_q;
    logic               cfg_wr;
    t_cmd               cmd;
    t_sts               sts;

    // config registers, writes are to be issued only while the core is idle; the core does not enforce this
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use   <= '0;
            r_fixed_focal_q <= FIXED_FOCAL_RESET;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_ROWS_IN_USE: r_rows_in_use   <= i_cfg_wdata[ROWS_W-1:0];
                CFG_FIXED_FOCAL: r_fixed_focal_q <= i_cfg_wdata;
                default: begin
                    // unknown index, write is dropped
                end
            endcase
        end
    end

    // sequencer: clamp checks, bracket scan, multiply, divide
    clit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // row table, bracket registers and arithmetic
    clit_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_row_index     (i_row_index),
        .i_zoom_value    (i_zoom_value),
        .i_row_focal_q   (i_row_focal_q),
        .i_rows_in_use   (r_rows_in_use),
        .i_fixed_focal_q (r_fixed_focal_q),
        .o_focal_q       (o_focal_q),
        .o_focal_valid   (o_focal_valid)
    );

    // a result only follows a busy cycle and never overlaps one
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_focal_valid |-> ($past(busy) && !busy))
        else $error("result strobe without a preceding query");

    // a row write neither blocks the core nor produces a result
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_req_type) |=> (!o_focal_valid && !busy))
        else $error("row write produced a result or stalled");

    // an accepted query always keeps the core busy in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type) |=> busy)
        else $error("query accepted but core not busy");

endmodule

`default_nettype wire

// File: rtl/core/clit_ram.sv
// generic single port ram with registered read
`default_nettype none

module clit_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/clit_ctrl.sv
// controller state machine: sequences clamps, row scan, multiply and divide
`default_nettype none

module clit_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_req_type,
    input  wire clit_pkg::t_sts i_sts,
    output clit_pkg::t_cmd     o_cmd,
    output logic               o_busy
);

    import clit_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.rd_sel  = RD_ZERO;
        o_cmd.out_sel = OUT_FIXED;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_req_type) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_FIRST;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_FIRST: begin
                if (i_sts.empty) begin
                    o_cmd.out_en  = 1'b1;
                    o_cmd.out_sel = OUT_FIXED;
                    n_state       = S_IDLE;
                end else if (i_sts.zoom_le_row) begin
                    o_cmd.out_en  = 1'b1;
                    o_cmd.out_sel = OUT_ROW;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.save_lo = 1'b1;
                    o_cmd.rd_sel  = RD_LAST;
                    n_state       = S_LAST;
                end
            end
            S_LAST: begin
                if (i_sts.zoom_ge_row) begin
                    o_cmd.out_en  = 1'b1;
                    o_cmd.out_sel = OUT_ROW;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_sel = RD_ONE;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.zoom_le_row) begin
                    if (i_sts.row_le_lo) begin
                        o_cmd.out_en  = 1'b1;
                        o_cmd.out_sel = OUT_LO;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.setup = 1'b1;
                        n_state     = S_MUL;
                    end
                end else begin
                    o_cmd.save_lo = 1'b1;
                    o_cmd.rd_sel  = RD_NEXT;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.out_en  = 1'b1;
                o_cmd.out_sel = OUT_INTERP;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/clit_dp.sv
// datapath: row table, bracketing registers, multiplier and serial divider
`default_nettype none

module clit_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire clit_pkg::t_cmd                     i_cmd,
    output clit_pkg::t_sts                          o_sts,
    input  wire logic [clit_pkg::ROW_IDX_W-1:0]     i_row_index,
    input  wire logic [clit_pkg::KEY_W-1:0]         i_zoom_value,
    input  wire logic [clit_pkg::FOCAL_W-1:0]       i_row_focal_q,
    input  wire logic [clit_pkg::ROWS_W-1:0]        i_rows_in_use,
    input  wire logic [clit_pkg::FOCAL_W-1:0]       i_fixed_focal_q,
    output logic      [clit_pkg::FOCAL_W-1:0]       o_focal_q,
    output logic                                    o_focal_valid
);

    import clit_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WIDE_W = (CNT_W > ROWS_W) ? CNT_W : ROWS_W;

    // query registers
    logic [KEY_W-1:0]     r_zoom;
    logic                 r_empty;
    logic [IDX_W-1:0]     r_last;
    logic [IDX_W-1:0]     r_idx;
    logic [KEY_W-1:0]     r_lo_key;
    logic [FOCAL_W-1:0]   r_lo_focal;
    logic [KEY_W-1:0]     r_span;
    logic [KEY_W-1:0]     r_off;
    logic [FOCAL_W-1:0]   r_mag;
    logic                 r_neg;
    logic [KEY_W-1:0]     r_rem;
    logic [FOCAL_W-1:0]   r_dvd;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [FOCAL_W-1:0]   r_focal_q;
    logic                 r_focal_valid;

    logic [WIDE_W-1:0]    wide_rows;
    logic [WIDE_W-1:0]    wide_n;
    logic [WIDE_W-1:0]    wide_last;
    logic [WIDE_W-1:0]    wide_row_idx;
    logic                 wr_ok;
    logic [IDX_W-1:0]     ram_addr;
    logic [ROW_W-1:0]     ram_rdata;
    logic [KEY_W-1:0]     row_key;
    logic [FOCAL_W-1:0]   row_focal;
    logic [PROD_W-1:0]    prod;
    logic [KEY_W:0]       rem_sh;
    logic [KEY_W:0]       rem_diff;
    logic                 q_bit;
    logic [FOCAL_W-1:0]   interp;

    // row count saturates at the table depth
    assign wide_rows    = WIDE_W'(i_rows_in_use);
    assign wide_n       = (wide_rows > WIDE_W'(TABLE_DEPTH)) ? WIDE_W'(TABLE_DEPTH) : wide_rows;
    assign wide_last    = wide_n - WIDE_W'(1);
    assign wide_row_idx = WIDE_W'(i_row_index);
    assign wr_ok        = i_cmd.wr && (wide_row_idx < WIDE_W'(TABLE_DEPTH));

    always_comb begin
        case (i_cmd.rd_sel)
            RD_ZERO: ram_addr = '0;
            RD_LAST: ram_addr = r_last;
            RD_ONE:  ram_addr = IDX_W'(1);
            RD_NEXT: ram_addr = r_idx + IDX_W'(1);
            default: ram_addr = '0;
        endcase
        if (i_cmd.wr) begin
            ram_addr = wide_row_idx[IDX_W-1:0];
        end
    end

    clit_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_addr  (ram_addr),
        .i_wdata ({i_zoom_value, i_row_focal_q}),
        .o_rdata (ram_rdata)
    );

    assign row_key   = ram_rdata[ROW_W-1:FOCAL_W];
    assign row_focal = ram_rdata[FOCAL_W-1:0];

    assign o_sts.empty       = r_empty;
    assign o_sts.zoom_le_row = (r_zoom <= row_key);
    assign o_sts.zoom_ge_row = (r_zoom >= row_key);
    assign o_sts.row_le_lo   = (row_key <= r_lo_key);
    assign o_sts.div_last    = (r_div_cnt == DIV_LAST);

    assign prod     = PROD_W'(r_off) * PROD_W'(r_mag);
    assign rem_sh   = {r_rem, r_dvd[FOCAL_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, r_span});
    assign rem_diff = rem_sh - {1'b0, r_span};
    assign interp   = r_neg ? (r_lo_focal - r_dvd) : (r_lo_focal + r_dvd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_zoom  <= i_zoom_value;
            r_empty <= (wide_n == '0);
            r_last  <= wide_last[IDX_W-1:0];
        end
        if (i_cmd.rd_sel == RD_ONE) begin
            r_idx <= IDX_W'(1);
        end else if (i_cmd.rd_sel == RD_NEXT) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.save_lo) begin
            r_lo_key   <= row_key;
            r_lo_focal <= row_focal;
        end
        if (i_cmd.setup) begin
            r_span <= row_key - r_lo_key;
            r_off  <= r_zoom - r_lo_key;
            r_neg  <= (row_focal < r_lo_focal);
            r_mag  <= (row_focal < r_lo_focal) ? (r_lo_focal - row_focal)
                                               : (row_focal - r_lo_focal);
        end
        // product high half is below the span, so the quotient fits 24 bits
        if (i_cmd.mul) begin
            r_rem <= prod[PROD_W-1:FOCAL_W];
            r_dvd <= prod[FOCAL_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? rem_diff[KEY_W-1:0] : rem_sh[KEY_W-1:0];
            r_dvd <= {r_dvd[FOCAL_W-2:0], q_bit};
        end
        if (i_cmd.out_en) begin
            case (i_cmd.out_sel)
                OUT_FIXED:  r_focal_q <= i_fixed_focal_q;
                OUT_ROW:    r_focal_q <= row_focal;
                OUT_LO:     r_focal_q <= r_lo_focal;
                OUT_INTERP: r_focal_q <= interp;
                default:    r_focal_q <= i_fixed_focal_q;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt     <= '0;
            r_focal_valid <= 1'b0;
        end else begin
            r_focal_valid <= i_cmd.out_en;
            if (i_cmd.mul) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end
        end
    end

    assign o_focal_q     = r_focal_q;
    assign o_focal_valid = r_focal_valid;

endmodule

`default_nettype wire
